@@ src/ils_pkg.sv @@
// ---------------------------------------------------------------------------
// ils_pkg: shared types and constants for the interval list subtractor
// Holds list sizing, operation codes, controller states and entry types.
// ---------------------------------------------------------------------------
package ils_pkg;

	localparam int MAX_RANGES  = 16;
	localparam int IDX_W       = $clog2(MAX_RANGES);
	localparam int CNT_W       = $clog2(MAX_RANGES + 1);
	localparam int ADDR_W      = 32;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [1:0] {
		FN_INIT  = 2'd0,
		FN_SUB   = 2'd1,
		FN_TRIM  = 2'd2,
		FN_QUERY = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_APPEND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] end_addr;
	} entry_t;

	typedef struct packed {
		logic split;
		logic dropped;
	} upd_flags_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ src/ils_ram.sv @@
// ---------------------------------------------------------------------------
// ils_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module ils_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/ils_entry_upd.sv @@
// ---------------------------------------------------------------------------
// ils_entry_upd: update of one list entry
// Applies a subtract or trim to one entry and reports its new size.
// ---------------------------------------------------------------------------
module ils_entry_upd
	import ils_pkg::*;
(
	input  func_t             func,
	input  logic [ADDR_W-1:0] lo,
	input  logic [ADDR_W-1:0] hi,
	input  entry_t            cur,
	input  logic              room,
	output entry_t            nxt,
	output upd_flags_t        flags,
	output logic [ADDR_W-1:0] size
);

	always_comb begin
		nxt   = cur;
		flags = '0;
		case (func)
			FN_SUB: begin
				if (lo <= cur.start_addr && hi > cur.start_addr) begin
					nxt.start_addr = (hi >= cur.end_addr) ? cur.end_addr : hi;
				end else if (lo < cur.end_addr && hi >= cur.end_addr) begin
					nxt.end_addr = (lo <= cur.start_addr) ? cur.start_addr : lo;
				end else if (lo >= cur.start_addr && hi <= cur.end_addr) begin
					if (room) begin
						nxt.end_addr = lo;
						flags.split  = 1'b1;
					end else begin
						flags.dropped = 1'b1;
					end
				end
			end
			FN_TRIM: begin
				if (cur.end_addr == hi) begin
					nxt.start_addr = cur.end_addr;
				end
			end
			default: begin
			end
		endcase
	end

	assign size = nxt.end_addr - nxt.start_addr;

endmodule

@@ src/interval_list_subtractor_unit.sv @@
// ---------------------------------------------------------------------------
// interval_list_subtractor_unit: list of address ranges with subtraction
// Keeps up to sixteen ranges in a list memory and reports the largest one.
// ---------------------------------------------------------------------------
// The input channel takes one beat per operation: init, subtract, trim or
// query. Each beat produces exactly one output beat with the largest range,
// its size, the entry count and the split-dropped flag.
// An operation walks the list memory one entry per cycle, reading the next
// entry while the current one is written back (a query writes nothing back);
// a split holds the walk while the new entry is appended at the end of the
// list. Init and operations on an empty list go straight from the idle to
// the done state. The input is taken only while no operation is in progress,
// so a new beat waits until the previous operation leaves its done state.
// A finished result waits in the output register, and the next operation
// is accepted and walked while it waits; that operation holds in its final
// state until the receiver takes the older beat.
// Reset empties the list and drops any pending result. The memory contents
// need no clearing, since only entries below the count are ever used.
// ---------------------------------------------------------------------------
module interval_list_subtractor_unit
	import ils_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             func,
	input  logic [ADDR_W-1:0]      lo_addr,
	input  logic [ADDR_W-1:0]      hi_addr,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ADDR_W-1:0]      largest_start,
	output logic [ADDR_W-1:0]      largest_size,
	output logic [COUNT_OUT_W-1:0] range_count,
	output logic                   split_dropped
);

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    out_valid_q;

	func_t                   func_q;
	logic [ADDR_W-1:0]       lo_q, hi_q;
	logic [ADDR_W-1:0]       best_start_q, best_size_q;
	logic [ADDR_W-1:0]       split_end_q;
	logic                    dropped_q;
	logic [ADDR_W-1:0]       out_start_q, out_size_q;
	logic [COUNT_OUT_W-1:0]  out_count_q;
	logic                    out_drop_q;

	logic                    accept, room, more, out_free;
	logic [IDX_W-1:0]        idx_nxt;
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr, ram_raddr;
	entry_t                  ram_wdata, ram_rdata;
	entry_t                  upd_entry;
	upd_flags_t              upd_flags;
	logic [ADDR_W-1:0]       upd_size;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign room     = (count_q < CNT_W'(MAX_RANGES));
	assign idx_nxt  = idx_q + IDX_W'(1);
	assign more     = ((CNT_W'(idx_q) + CNT_W'(1)) < count_q);
	assign out_free = !out_valid_q || out_ready;

	ils_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_RANGES)
	) u_list_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ils_entry_upd u_entry_upd (
		.func  (func_q),
		.lo    (lo_q),
		.hi    (hi_q),
		.cur   (ram_rdata),
		.room  (room),
		.nxt   (upd_entry),
		.flags (upd_flags),
		.size  (upd_size)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = upd_entry;
		ram_raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = '0;
				if (accept) begin
					if (func_t'(func) == FN_INIT) begin
						ram_we    = 1'b1;
						ram_waddr = '0;
						ram_wdata = '{start_addr: lo_addr, end_addr: hi_addr};
						state_d   = ST_DONE;
					end else if (count_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				ram_we    = (func_q != FN_QUERY);
				ram_raddr = idx_nxt;
				if (upd_flags.split) begin
					state_d = ST_APPEND;
				end else if (more) begin
					state_d = ST_EVAL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = count_q[IDX_W-1:0];
				ram_wdata = '{start_addr: hi_q, end_addr: split_end_q};
				state_d   = ST_READ;
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept && func_t'(func) == FN_INIT) begin
						count_q <= CNT_W'(1);
					end
				end
				ST_EVAL: begin
					if (!upd_flags.split && more) begin
						idx_q <= idx_nxt;
					end
				end
				ST_APPEND: begin
					count_q <= count_q + CNT_W'(1);
					idx_q   <= idx_nxt;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q    <= func_t'(func);
					lo_q      <= lo_addr;
					hi_q      <= hi_addr;
					dropped_q <= 1'b0;
					if (func_t'(func) == FN_INIT) begin
						best_start_q <= lo_addr;
						best_size_q  <= hi_addr - lo_addr;
					end else begin
						best_start_q <= '0;
						best_size_q  <= '0;
					end
				end
			end
			ST_EVAL: begin
				if (idx_q == '0 || upd_size > best_size_q) begin
					best_start_q <= upd_entry.start_addr;
					best_size_q  <= upd_size;
				end
				if (upd_flags.dropped) begin
					dropped_q <= 1'b1;
				end
				if (upd_flags.split) begin
					split_end_q <= ram_rdata.end_addr;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_start_q <= best_start_q;
					out_size_q  <= best_size_q;
					out_count_q <= COUNT_OUT_W'(count_q);
					out_drop_q  <= dropped_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign largest_start = out_start_q;
	assign largest_size  = out_size_q;
	assign range_count   = out_count_q;
	assign split_dropped = out_drop_q;

endmodule

@@ src/ils_checker.sv @@
// ---------------------------------------------------------------------------
// ils_checker: port-level checks for the interval list subtractor
// Watches the input and output channels and the consistency of reported results.
// ---------------------------------------------------------------------------
module ils_checker
	import ils_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [ADDR_W-1:0]      largest_start,
	input logic [ADDR_W-1:0]      largest_size,
	input logic [COUNT_OUT_W-1:0] range_count,
	input logic                   split_dropped
);

	a_in_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken again right after a beat.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(largest_start)
			&& $stable(largest_size) && $stable(range_count) && $stable(split_dropped))
		else $error("Output beat changed while stalled.");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> range_count <= COUNT_OUT_W'(MAX_RANGES))
		else $error("Reported count exceeds the list capacity.");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && split_dropped |-> range_count == COUNT_OUT_W'(MAX_RANGES))
		else $error("Split dropped while the list was not full.");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_count == '0 |-> largest_start == '0 && largest_size == '0)
		else $error("Empty list reported a nonzero range.");

endmodule

bind interval_list_subtractor_unit ils_checker u_ils_checker (.*);
